### rtl/core/two_point_sensor_calibration_defines.svh
// ----------------------------------------------------------------------------
// two point sensor calibration assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_SENSOR_CALIBRATION_DEFINES_SVH
`define TWO_POINT_SENSOR_CALIBRATION_DEFINES_SVH

// same-cycle implication
`define TPSC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tpsc assertion failed");

// next-cycle implication
`define TPSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tpsc assertion failed");

`endif

### rtl/core/tpsc_pkg.sv
// ----------------------------------------------------------------------------
// tpsc_pkg
// widths, register codes and pipeline stage types of the calibration block
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int XW  = 16;          // raw count width
  localparam int YW  = 10;          // calibration point width (widest lane)
  localparam int DW  = XW + 1;      // raw difference width
  localparam int DYW = YW + 1;      // point difference width
  localparam int PW  = DW + DYW;    // product width
  localparam int SW  = PW + 1;      // sum of products width
  localparam int NW  = 32;          // ten times the sum, signed
  localparam int MW  = NW - 1;      // dividend magnitude
  localparam int DMW = DW + 3;      // divisor magnitude, up to eight times |d|
  localparam int QW  = 17;          // quotient magnitude bits kept
  localparam int CW  = DMW + QW;    // compare width in the divider

  localparam int TEMP_SCALE_SHIFT = 3;  // divide by eight
  localparam int HUM_SCALE_SHIFT  = 1;  // divide by two

  localparam int CFG_IW = 4;
  localparam int CFG_DW = 16;

  localparam logic signed [XW-1:0] RES_MAX = 16'sh7fff;
  localparam logic signed [XW-1:0] RES_MIN = 16'sh8000;

  typedef enum logic [CFG_IW-1:0] {
    CFG_HUM_LOW_POINT_X2   = 4'd0,
    CFG_HUM_HIGH_POINT_X2  = 4'd1,
    CFG_HUM_LOW_RAW        = 4'd2,
    CFG_HUM_HIGH_RAW       = 4'd3,
    CFG_TEMP_LOW_POINT_X8  = 4'd4,
    CFG_TEMP_HIGH_POINT_X8 = 4'd5,
    CFG_TEMP_LOW_RAW       = 4'd6,
    CFG_TEMP_HIGH_RAW      = 4'd7
  } cfg_index_t;

  typedef struct packed {
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  d;
    logic signed [DYW-1:0] dy;
    logic [YW-1:0]         y0;
  } front_t;

  typedef struct packed {
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic [YW-1:0]        y0;
    logic                 dzero;
    logic                 dneg;
    logic [DW-1:0]        dmag;
  } prod_t;

  typedef struct packed {
    logic signed [SW-1:0] sum;
    logic [YW-1:0]        y0;
    logic                 dzero;
    logic                 dneg;
    logic [DW-1:0]        dmag;
  } sum_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [MW-1:0]  rem;
    logic [DMW-1:0] den;
    logic [QW-1:0]  quo;
  } div_t;

endpackage

### rtl/core/two_point_sensor_calibration.sv
// ----------------------------------------------------------------------------
// two_point_sensor_calibration
// Converts a raw humidity and temperature count pair into tenths of a percent
// and tenths of a degree by linear interpolation between two calibration
// points per channel, truncated toward zero and saturated to 16 bits signed.
// The block takes one reading transaction per clock while in_ready is high,
// which drops only when every stage is full and the output is stalled, and
// returns one result transaction per reading. A restoring divider settles
// one quotient bit per pipeline stage, 17 stages, behind five stages of
// differences, products, sums, sign handling and range check, plus the output
// register. Every stage carries its own valid bit and may load whenever it is
// empty or its successor moves, so bubbles close up under a stall and a new
// reading is taken while a finished result still waits. A zero span between
// the raw calibration counts yields the low point in tenths. The calibration
// registers are written through the cfg port (always ready) and must only
// change while no reading is in flight.
// ----------------------------------------------------------------------------
`include "two_point_sensor_calibration_defines.svh"

module two_point_sensor_calibration (
  input  logic                               clk,
  input  logic                               rst,
  // reading channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tpsc_pkg::XW-1:0]     raw_humidity,
  input  logic signed [tpsc_pkg::XW-1:0]     raw_temperature,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tpsc_pkg::XW-1:0]     temperature_tenths,
  output logic signed [tpsc_pkg::XW-1:0]     humidity_tenths,
  // calibration register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpsc_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [tpsc_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int NS    = tpsc_pkg::QW + 6;  // total register stages
  localparam int LANES = 2;
  localparam int LT    = 0;                 // temperature lane
  localparam int LH    = 1;                 // humidity lane

  // calibration registers
  logic [7:0]                        hum_low_point_x2;
  logic [7:0]                        hum_high_point_x2;
  logic signed [tpsc_pkg::XW-1:0]    hum_low_raw;
  logic signed [tpsc_pkg::XW-1:0]    hum_high_raw;
  logic [tpsc_pkg::YW-1:0]           temp_low_point_x8;
  logic [tpsc_pkg::YW-1:0]           temp_high_point_x8;
  logic signed [tpsc_pkg::XW-1:0]    temp_low_raw;
  logic signed [tpsc_pkg::XW-1:0]    temp_high_raw;

  // pipeline occupancy and per-stage load enables
  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  // lane views for the checks below
  logic [LANES-1:0] last_rem_ok;
  logic [LANES-1:0] last_ovf;
  logic [LANES-1:0] last_neg;

  logic signed [tpsc_pkg::XW-1:0] lane_res [LANES];

  // --------------------------------------------------------------------------
  // stage functions
  // --------------------------------------------------------------------------

  // differences against the low calibration point
  function automatic tpsc_pkg::front_t f_front(
    input logic signed [tpsc_pkg::XW-1:0] x,
    input logic signed [tpsc_pkg::XW-1:0] x0,
    input logic signed [tpsc_pkg::XW-1:0] x1,
    input logic [tpsc_pkg::YW-1:0]        y0,
    input logic [tpsc_pkg::YW-1:0]        y1
  );
    tpsc_pkg::front_t f;
    f.dx = $signed({x[tpsc_pkg::XW-1], x}) - $signed({x0[tpsc_pkg::XW-1], x0});
    f.d  = $signed({x1[tpsc_pkg::XW-1], x1}) - $signed({x0[tpsc_pkg::XW-1], x0});
    f.dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
    f.y0 = y0;
    return f;
  endfunction

  // y0*d and (x-x0)*(y1-y0), span magnitude alongside
  function automatic tpsc_pkg::prod_t f_prod(input tpsc_pkg::front_t f);
    tpsc_pkg::prod_t p;
    logic signed [tpsc_pkg::DW-1:0] d;
    logic signed [tpsc_pkg::DW-1:0] dx;
    logic signed [tpsc_pkg::DYW-1:0] dy;
    d  = $signed(f.d);
    dx = $signed(f.dx);
    dy = $signed(f.dy);
    p.p1    = tpsc_pkg::PW'($signed({1'b0, f.y0})) * tpsc_pkg::PW'(d);
    p.p2    = tpsc_pkg::PW'(dx) * tpsc_pkg::PW'(dy);
    p.y0    = f.y0;
    p.dzero = (d == '0);
    p.dneg  = d[tpsc_pkg::DW-1];
    p.dmag  = d[tpsc_pkg::DW-1] ? tpsc_pkg::DW'(-d) : tpsc_pkg::DW'(d);
    return p;
  endfunction

  function automatic tpsc_pkg::sum_t f_sum(input tpsc_pkg::prod_t p);
    tpsc_pkg::sum_t s;
    s.sum   = tpsc_pkg::SW'($signed(p.p1)) + tpsc_pkg::SW'($signed(p.p2));
    s.y0    = p.y0;
    s.dzero = p.dzero;
    s.dneg  = p.dneg;
    s.dmag  = p.dmag;
    return s;
  endfunction

  // times ten, split into sign and magnitude, divisor scaled by the lane
  function automatic tpsc_pkg::div_t f_init(input tpsc_pkg::sum_t s, input int sh);
    tpsc_pkg::div_t r;
    logic signed [tpsc_pkg::NW-1:0] src;
    logic signed [tpsc_pkg::NW-1:0] n10;
    logic [tpsc_pkg::NW-1:0]        nabs;
    src  = s.dzero ? tpsc_pkg::NW'($signed({1'b0, s.y0}))
                   : tpsc_pkg::NW'($signed(s.sum));
    n10  = (src <<< 3) + (src <<< 1);
    nabs = n10[tpsc_pkg::NW-1] ? tpsc_pkg::NW'(-n10) : tpsc_pkg::NW'(n10);
    r.neg = n10[tpsc_pkg::NW-1] ^ (s.dneg & ~s.dzero);
    r.ovf = 1'b0;
    r.rem = nabs[tpsc_pkg::MW-1:0];
    r.den = s.dzero ? (tpsc_pkg::DMW'(1) << sh) : (tpsc_pkg::DMW'(s.dmag) << sh);
    r.quo = '0;
    return r;
  endfunction

  // quotient would not fit the kept bits
  function automatic tpsc_pkg::div_t f_ovf(input tpsc_pkg::div_t d);
    tpsc_pkg::div_t r;
    r     = d;
    r.ovf = tpsc_pkg::CW'(d.rem) >= (tpsc_pkg::CW'(d.den) << tpsc_pkg::QW);
    return r;
  endfunction

  // one restoring step, quotient bit b
  function automatic tpsc_pkg::div_t f_bit(input tpsc_pkg::div_t d, input int b);
    tpsc_pkg::div_t r;
    logic [tpsc_pkg::CW-1:0] trial;
    logic [tpsc_pkg::CW-1:0] rem_w;
    r     = d;
    trial = tpsc_pkg::CW'(d.den) << b;
    rem_w = tpsc_pkg::CW'(d.rem);
    if (rem_w >= trial) begin
      rem_w    = rem_w - trial;
      r.rem    = rem_w[tpsc_pkg::MW-1:0];
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  // apply sign and clamp to the 16 bit range
  function automatic logic signed [tpsc_pkg::XW-1:0] f_sat(input tpsc_pkg::div_t d);
    logic [tpsc_pkg::QW-1:0]        nq;
    logic signed [tpsc_pkg::XW-1:0] r;
    nq = tpsc_pkg::QW'(~d.quo + 1'b1);
    if (d.neg) begin
      r = (d.ovf || d.quo > tpsc_pkg::QW'(32768)) ? tpsc_pkg::RES_MIN
                                                  : $signed(nq[tpsc_pkg::XW-1:0]);
    end else begin
      r = (d.ovf || d.quo > tpsc_pkg::QW'(32767)) ? tpsc_pkg::RES_MAX
                                                  : $signed(d.quo[tpsc_pkg::XW-1:0]);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // calibration register writes, unknown indexes ignored
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hum_low_point_x2   <= '0;
      hum_high_point_x2  <= '0;
      hum_low_raw        <= '0;
      hum_high_raw       <= '0;
      temp_low_point_x8  <= '0;
      temp_high_point_x8 <= '0;
      temp_low_raw       <= '0;
      temp_high_raw      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tpsc_pkg::cfg_index_t'(cfg_index))
        tpsc_pkg::CFG_HUM_LOW_POINT_X2:   hum_low_point_x2   <= cfg_data[7:0];
        tpsc_pkg::CFG_HUM_HIGH_POINT_X2:  hum_high_point_x2  <= cfg_data[7:0];
        tpsc_pkg::CFG_HUM_LOW_RAW:        hum_low_raw        <= $signed(cfg_data);
        tpsc_pkg::CFG_HUM_HIGH_RAW:       hum_high_raw       <= $signed(cfg_data);
        tpsc_pkg::CFG_TEMP_LOW_POINT_X8:  temp_low_point_x8  <= cfg_data[tpsc_pkg::YW-1:0];
        tpsc_pkg::CFG_TEMP_HIGH_POINT_X8: temp_high_point_x8 <= cfg_data[tpsc_pkg::YW-1:0];
        tpsc_pkg::CFG_TEMP_LOW_RAW:       temp_low_raw       <= $signed(cfg_data);
        tpsc_pkg::CFG_TEMP_HIGH_RAW:      temp_high_raw      <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  assign rdy[NS] = out_ready;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  // --------------------------------------------------------------------------
  // datapath, one lane per quantity
  // --------------------------------------------------------------------------
  for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
    localparam int SH = (ln == LT) ? tpsc_pkg::TEMP_SCALE_SHIFT
                                   : tpsc_pkg::HUM_SCALE_SHIFT;

    logic signed [tpsc_pkg::XW-1:0] x;
    logic signed [tpsc_pkg::XW-1:0] x0;
    logic signed [tpsc_pkg::XW-1:0] x1;
    logic [tpsc_pkg::YW-1:0]        y0;
    logic [tpsc_pkg::YW-1:0]        y1;

    tpsc_pkg::front_t s_front;
    tpsc_pkg::prod_t  s_prod;
    tpsc_pkg::sum_t   s_sum;
    // [0] sign split, [1] range check, [2..] one quotient bit each
    tpsc_pkg::div_t   s_div [tpsc_pkg::QW+2];

    if (ln == LT) begin : g_temp
      assign x  = raw_temperature;
      assign x0 = temp_low_raw;
      assign x1 = temp_high_raw;
      assign y0 = temp_low_point_x8;
      assign y1 = temp_high_point_x8;
    end else begin : g_hum
      assign x  = raw_humidity;
      assign x0 = hum_low_raw;
      assign x1 = hum_high_raw;
      assign y0 = tpsc_pkg::YW'(hum_low_point_x2);
      assign y1 = tpsc_pkg::YW'(hum_high_point_x2);
    end

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        s_front <= f_front(x, x0, x1, y0, y1);
      end
      if (rdy[1]) begin
        s_prod <= f_prod(s_front);
      end
      if (rdy[2]) begin
        s_sum <= f_sum(s_prod);
      end
      if (rdy[3]) begin
        s_div[0] <= f_init(s_sum, SH);
      end
      if (rdy[4]) begin
        s_div[1] <= f_ovf(s_div[0]);
      end
    end

    // most significant quotient bit first
    for (genvar j = 0; j < tpsc_pkg::QW; j++) begin : g_bit
      always_ff @(posedge clk) begin
        if (rdy[5+j]) begin
          s_div[j+2] <= f_bit(s_div[j+1], tpsc_pkg::QW-1-j);
        end
      end
    end

    // output register
    always_ff @(posedge clk) begin
      if (rdy[NS-1]) begin
        lane_res[ln] <= f_sat(s_div[tpsc_pkg::QW+1]);
      end
    end

    assign last_rem_ok[ln] = s_div[tpsc_pkg::QW+1].ovf ||
                             (tpsc_pkg::DMW'(s_div[tpsc_pkg::QW+1].rem) <
                              s_div[tpsc_pkg::QW+1].den);
    assign last_ovf[ln]    = s_div[tpsc_pkg::QW+1].ovf;
    assign last_neg[ln]    = s_div[tpsc_pkg::QW+1].neg;
  end

  assign temperature_tenths = lane_res[LT];
  assign humidity_tenths    = lane_res[LH];

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // the divider leaves a remainder below the divisor unless the range check tripped
  `TPSC_ASSERT_NOW(a_rem_below_den, v[NS-2], &last_rem_ok)
  // input is only held off when every stage is occupied
  `TPSC_ASSERT_NOW(a_stall_only_when_full, !in_ready, (&v) && !out_ready)
  // a positive out-of-range temperature reaches the output clamped high
  `TPSC_ASSERT_NEXT(a_temp_clamp_high,
                    v[NS-2] && rdy[NS-1] && last_ovf[LT] && !last_neg[LT],
                    out_valid && (temperature_tenths == tpsc_pkg::RES_MAX))

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// two point sensor calibration testbench
// streams raw humidity and temperature pairs through the calibration block
// under several register settings, predicts each converted pair in a small
// scoreboard and compares every result transaction field by field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int          ITEMS_PER_PHASE = 150;
  localparam int          RANDOM_PHASES   = 11;
  localparam int          HOLD_CYCLES     = 120;   // long output hold-off
  localparam int          SETTLE_CYCLES   = 40;    // pipeline is 23 deep
  localparam int unsigned CYCLE_LIMIT     = 250_000;
  localparam int          MAX_PRINTED     = 40;

  // register indexes from here up decode to nothing
  localparam logic [tpsc_pkg::CFG_IW-1:0] CFG_UNUSED_FIRST = 4'd8;

  localparam logic signed [tpsc_pkg::XW-1:0] RAW_MAX = 16'sh7fff;
  localparam logic signed [tpsc_pkg::XW-1:0] RAW_MIN = 16'sh8000;

  typedef struct {
    logic signed [tpsc_pkg::XW-1:0] hum;
    logic signed [tpsc_pkg::XW-1:0] temp;
  } reading_t;

  typedef struct {
    logic signed [tpsc_pkg::XW-1:0] temp_tenths;
    logic signed [tpsc_pkg::XW-1:0] hum_tenths;
  } tenths_t;

  // calibration set, fields in register index order
  typedef struct {
    logic [7:0]                     hum_lo_pt;
    logic [7:0]                     hum_hi_pt;
    logic signed [tpsc_pkg::XW-1:0] hum_lo_raw;
    logic signed [tpsc_pkg::XW-1:0] hum_hi_raw;
    logic [9:0]                     temp_lo_pt;
    logic [9:0]                     temp_hi_pt;
    logic signed [tpsc_pkg::XW-1:0] temp_lo_raw;
    logic signed [tpsc_pkg::XW-1:0] temp_hi_raw;
  } cal_t;

  typedef enum {CAL_SPREAD, CAL_EXTREME, CAL_FLAT, CAL_STEEP, CAL_NOISE} cal_style_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the calibration registers and a queue of the
  // converted pairs still owed by the block
  // --------------------------------------------------------------------------
  class calib_scoreboard;
    cal_t    regs;
    tenths_t expected_tenths[$];
    int      fails;

    function new();
      regs  = '{default: '0};
      fails = 0;
    endfunction

    // exact rational interpolation, one truncation toward zero, then clamp
    static function logic signed [tpsc_pkg::XW-1:0] interpolate_tenths(
        longint x0, longint y0, longint x1, longint y1, longint x, longint scale);
      longint span;
      longint tenths;
      span = x1 - x0;
      if (span == 0) begin
        tenths = (10 * y0) / scale;
      end else begin
        tenths = (10 * (y0 * span + (x - x0) * (y1 - y0))) / (scale * span);
      end
      if (tenths > longint'(tpsc_pkg::RES_MAX)) return tpsc_pkg::RES_MAX;
      if (tenths < longint'(tpsc_pkg::RES_MIN)) return tpsc_pkg::RES_MIN;
      return tpsc_pkg::XW'(tenths);
    endfunction

    function void set_register(logic [tpsc_pkg::CFG_IW-1:0] idx,
                               logic [tpsc_pkg::CFG_DW-1:0] data);
      case (idx)
        tpsc_pkg::CFG_HUM_LOW_POINT_X2:   regs.hum_lo_pt   = data[7:0];
        tpsc_pkg::CFG_HUM_HIGH_POINT_X2:  regs.hum_hi_pt   = data[7:0];
        tpsc_pkg::CFG_HUM_LOW_RAW:        regs.hum_lo_raw  = data;
        tpsc_pkg::CFG_HUM_HIGH_RAW:       regs.hum_hi_raw  = data;
        tpsc_pkg::CFG_TEMP_LOW_POINT_X8:  regs.temp_lo_pt  = data[9:0];
        tpsc_pkg::CFG_TEMP_HIGH_POINT_X8: regs.temp_hi_pt  = data[9:0];
        tpsc_pkg::CFG_TEMP_LOW_RAW:       regs.temp_lo_raw = data;
        tpsc_pkg::CFG_TEMP_HIGH_RAW:      regs.temp_hi_raw = data;
        default: ;
      endcase
    endfunction

    function void note_reading(logic signed [tpsc_pkg::XW-1:0] hum,
                               logic signed [tpsc_pkg::XW-1:0] temp);
      tenths_t want;
      want.temp_tenths = interpolate_tenths(regs.temp_lo_raw, regs.temp_lo_pt,
                                            regs.temp_hi_raw, regs.temp_hi_pt,
                                            temp, 1 << tpsc_pkg::TEMP_SCALE_SHIFT);
      want.hum_tenths  = interpolate_tenths(regs.hum_lo_raw, regs.hum_lo_pt,
                                            regs.hum_hi_raw, regs.hum_hi_pt,
                                            hum, 1 << tpsc_pkg::HUM_SCALE_SHIFT);
      expected_tenths.push_back(want);
    endfunction

    task report_mismatch(string what);
      if (fails < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    task check_result(logic signed [tpsc_pkg::XW-1:0] temp,
                      logic signed [tpsc_pkg::XW-1:0] hum);
      tenths_t want;
      if (expected_tenths.size() == 0) begin
        report_mismatch($sformatf("result temp %0d hum %0d with nothing owed", temp, hum));
        return;
      end
      want = expected_tenths.pop_front();
      if (temp !== want.temp_tenths)
        report_mismatch($sformatf("temperature_tenths %0d, want %0d",
                                  temp, want.temp_tenths));
      if (hum !== want.hum_tenths)
        report_mismatch($sformatf("humidity_tenths %0d, want %0d",
                                  hum, want.hum_tenths));
    endtask

    function int pending();
      return expected_tenths.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                           clk;
  logic                           rst             = 1'b1;
  logic                           in_valid        = 1'b0;
  logic                           in_ready;
  logic signed [tpsc_pkg::XW-1:0] raw_humidity    = '0;
  logic signed [tpsc_pkg::XW-1:0] raw_temperature = '0;
  logic                           out_valid;
  logic                           out_ready       = 1'b0;
  logic signed [tpsc_pkg::XW-1:0] temperature_tenths;
  logic signed [tpsc_pkg::XW-1:0] humidity_tenths;
  logic                           cfg_valid       = 1'b0;
  logic                           cfg_ready;
  logic [tpsc_pkg::CFG_IW-1:0]    cfg_index       = '0;
  logic [tpsc_pkg::CFG_DW-1:0]    cfg_data        = '0;

  calib_scoreboard sb = new();
  cal_t            cal_now = '{default: '0};   // last calibration set written
  int              holdoff_asks = 0;           // raised by the sender
  int              holdoffs_done = 0;          // followed by the receiver
  int unsigned     cycles = 0;

  two_point_sensor_calibration u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .raw_humidity       (raw_humidity),
    .raw_temperature    (raw_temperature),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .temperature_tenths (temperature_tenths),
    .humidity_tenths    (humidity_tenths),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: values seen at the edge are the ones before this edge's updates,
  // so every transaction is taken exactly as the block takes it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready)   sb.note_reading(raw_humidity, raw_temperature);
      if (out_valid && out_ready) sb.check_result(temperature_tenths, humidity_tenths);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stretches of random length, each with its own stall behaviour;
  // a hold-off asked by the sender parks out_ready low for a long stretch
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int stretch;
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_asks != holdoffs_done) begin
        holdoffs_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(10, 150);
        repeat (stretch) begin
          case (mode)
            0: out_ready <= 1'b1;                         // never stalls
            1: out_ready <= ($urandom_range(0, 3) != 0);  // light stalls
            2: out_ready <= ($urandom_range(0, 3) == 0);  // heavy stalls
            default: out_ready <= ~out_ready;             // alternates high and low
          endcase
          @(posedge clk);
          if (holdoff_asks != holdoffs_done) break;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic reading_t rd(int hum, int temp);
    reading_t r;
    r.hum  = tpsc_pkg::XW'(hum);
    r.temp = tpsc_pkg::XW'(temp);
    return r;
  endfunction

  function automatic cal_t make_cal(int hlp, int hhp, int hlr, int hhr,
                                    int tlp, int thp, int tlr, int thr);
    cal_t c;
    c.hum_lo_pt   = 8'(hlp);
    c.hum_hi_pt   = 8'(hhp);
    c.hum_lo_raw  = tpsc_pkg::XW'(hlr);
    c.hum_hi_raw  = tpsc_pkg::XW'(hhr);
    c.temp_lo_pt  = 10'(tlp);
    c.temp_hi_pt  = 10'(thp);
    c.temp_lo_raw = tpsc_pkg::XW'(tlr);
    c.temp_hi_raw = tpsc_pkg::XW'(thr);
    return c;
  endfunction

  // random calibration set; points are always random unless pinned to a rail
  function automatic cal_t random_cal(cal_style_t style);
    cal_t c;
    int   lo_h;
    int   lo_t;
    c.hum_lo_pt   = 8'($urandom);
    c.hum_hi_pt   = 8'($urandom);
    c.hum_lo_raw  = tpsc_pkg::XW'($urandom);
    c.hum_hi_raw  = tpsc_pkg::XW'($urandom);
    c.temp_lo_pt  = 10'($urandom);
    c.temp_hi_pt  = 10'($urandom);
    c.temp_lo_raw = tpsc_pkg::XW'($urandom);
    c.temp_hi_raw = tpsc_pkg::XW'($urandom);
    lo_h = int'($urandom_range(0, 20000)) - 10000;
    lo_t = int'($urandom_range(0, 20000)) - 10000;
    case (style)
      CAL_SPREAD: begin
        // realistic spans of either sign
        c.hum_lo_raw  = tpsc_pkg::XW'(lo_h);
        c.hum_hi_raw  = tpsc_pkg::XW'(lo_h + ($urandom_range(0, 3) == 0 ? -1 : 1)
                                       * int'($urandom_range(1, 20000)));
        c.temp_lo_raw = tpsc_pkg::XW'(lo_t);
        c.temp_hi_raw = tpsc_pkg::XW'(lo_t + ($urandom_range(0, 3) == 0 ? -1 : 1)
                                       * int'($urandom_range(1, 20000)));
      end
      CAL_EXTREME: begin
        c.hum_lo_pt   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        c.hum_hi_pt   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        c.hum_lo_raw  = $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
        c.hum_hi_raw  = $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
        c.temp_lo_pt  = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
        c.temp_hi_pt  = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
        c.temp_lo_raw = $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
        c.temp_hi_raw = $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
      end
      CAL_FLAT: begin
        // equal raw counts, result falls back to the low point
        c.hum_hi_raw  = c.hum_lo_raw;
        c.temp_hi_raw = c.temp_lo_raw;
      end
      CAL_STEEP: begin
        // spans of one to three counts, most readings saturate
        c.hum_hi_raw  = tpsc_pkg::XW'(int'(c.hum_lo_raw)
                                       + ($urandom_range(0, 1) ? -1 : 1)
                                       * int'($urandom_range(1, 3)));
        c.temp_hi_raw = tpsc_pkg::XW'(int'(c.temp_lo_raw)
                                       + ($urandom_range(0, 1) ? -1 : 1)
                                       * int'($urandom_range(1, 3)));
      end
      default: ;
    endcase
    return c;
  endfunction

  // half uniform, the rest close to a calibration point, on a rail, zero or minus one
  function automatic reading_t random_reading(cal_t c);
    reading_t r;
    int       sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      r.hum  = tpsc_pkg::XW'($urandom);
      r.temp = tpsc_pkg::XW'($urandom);
    end else if (sel < 8) begin
      r.hum  = tpsc_pkg::XW'(int'($urandom_range(0, 1) ? c.hum_lo_raw : c.hum_hi_raw)
                             + int'($urandom_range(0, 128)) - 64);
      r.temp = tpsc_pkg::XW'(int'($urandom_range(0, 1) ? c.temp_lo_raw : c.temp_hi_raw)
                             + int'($urandom_range(0, 128)) - 64);
    end else begin
      case ($urandom_range(0, 3))
        0: r.hum = RAW_MAX;
        1: r.hum = RAW_MIN;
        2: r.hum = '0;
        default: r.hum = '1;
      endcase
      case ($urandom_range(0, 3))
        0: r.temp = RAW_MAX;
        1: r.temp = RAW_MIN;
        2: r.temp = '0;
        default: r.temp = '1;
      endcase
    end
    return r;
  endfunction

  // one register write transaction; cfg_valid is left high for the next one
  task automatic cfg_write(input logic [tpsc_pkg::CFG_IW-1:0] idx,
                           input logic [tpsc_pkg::CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all eight registers, with junk above the width of each point register, then
  // a write to an undecoded index that must leave everything untouched
  task automatic apply_cal(input cal_t c);
    cfg_write(tpsc_pkg::CFG_HUM_LOW_POINT_X2,   {8'($urandom), c.hum_lo_pt});
    cfg_write(tpsc_pkg::CFG_HUM_HIGH_POINT_X2,  {8'($urandom), c.hum_hi_pt});
    cfg_write(tpsc_pkg::CFG_HUM_LOW_RAW,        c.hum_lo_raw);
    cfg_write(tpsc_pkg::CFG_HUM_HIGH_RAW,       c.hum_hi_raw);
    cfg_write(tpsc_pkg::CFG_TEMP_LOW_POINT_X8,  {6'($urandom), c.temp_lo_pt});
    cfg_write(tpsc_pkg::CFG_TEMP_HIGH_POINT_X8, {6'($urandom), c.temp_hi_pt});
    cfg_write(tpsc_pkg::CFG_TEMP_LOW_RAW,       c.temp_lo_raw);
    cfg_write(tpsc_pkg::CFG_TEMP_HIGH_RAW,      c.temp_hi_raw);
    cfg_write(tpsc_pkg::CFG_IW'($urandom_range(int'(CFG_UNUSED_FIRST),
                                               (1 << tpsc_pkg::CFG_IW) - 1)),
              tpsc_pkg::CFG_DW'($urandom));
    cfg_valid <= 1'b0;
    cal_now = c;
  endtask

  // sender: bursts of random length with random gaps, or back to back when
  // the output is being held off so that the pipeline fills and stalls
  task automatic stream_readings(input reading_t list[$], input bit back_to_back);
    int burst;
    burst = $urandom_range(1, 40);
    foreach (list[i]) begin
      in_valid        <= 1'b1;
      raw_humidity    <= list[i].hum;
      raw_temperature <= list[i].temp;
      do @(posedge clk); while (!in_ready);
      burst--;
      if (!back_to_back && burst == 0 && i != list.size() - 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
    end
    in_valid <= 1'b0;
  endtask

  // at least one edge first so the monitor has booked the last transaction
  task automatic drain_results();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    reading_t   batch[$];
    cal_style_t phase_style [RANDOM_PHASES];
    bit         squeeze;

    phase_style = '{CAL_SPREAD, CAL_EXTREME, CAL_FLAT, CAL_STEEP, CAL_NOISE, CAL_SPREAD,
                    CAL_NOISE, CAL_EXTREME, CAL_STEEP, CAL_SPREAD, CAL_NOISE};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at their reset value: zero span, zero points, all results zero
    batch = '{rd(0, 0), rd(32767, -32768), rd(-32768, 32767)};
    stream_readings(batch, 1'b0);
    drain_results();

    // widest span on both channels, points at their rails
    apply_cal(make_cal(0, 255, -32768, 32767, 0, 1023, -32768, 32767));
    batch = '{rd(-32768, -32768), rd(32767, 32767), rd(0, 0), rd(-1, -1),
              rd(12345, -12345)};
    stream_readings(batch, 1'b0);
    drain_results();

    // one count span: saturation at both rails
    apply_cal(make_cal(0, 255, 0, 1, 0, 1023, 0, 1));
    batch = '{rd(32767, 32767), rd(-32768, -32768), rd(0, 0), rd(1, 1), rd(-1, -1)};
    stream_readings(batch, 1'b0);
    drain_results();

    // falling span, readings on both calibration points and on the rails
    apply_cal(make_cal(180, 40, 500, -1500, 800, 160, 1000, -1000));
    batch = '{rd(500, 1000), rd(-1500, -1000), rd(-32768, 32767), rd(32767, -32768),
              rd(7, -3)};
    stream_readings(batch, 1'b0);
    drain_results();

    // equal raw counts with the low points at their maximum
    apply_cal(make_cal(255, 0, 1234, 1234, 1023, 0, 1234, 1234));
    batch = '{rd(1234, 1234), rd(-32768, 32767), rd(0, 0)};
    stream_readings(batch, 1'b0);
    drain_results();

    // random phases, each under a fresh calibration set
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_cal(random_cal(phase_style[phase]));
      batch.delete();
      repeat (ITEMS_PER_PHASE) batch.push_back(random_reading(cal_now));
      squeeze = (phase % 5 == 2);
      if (squeeze) holdoff_asks++;
      stream_readings(batch, squeeze);
      drain_results();
    end

    // let anything stray fall out of the pipeline before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### two_point_sensor_calibration.f
+incdir+rtl/core
rtl/core/tpsc_pkg.sv
rtl/core/two_point_sensor_calibration.sv
sim/tb.sv
